>>> src/per_cpu_page_allocator_with_stealing_macros.svh
// Assertion macros shared by the page allocator RTL.
// Compiled out when SYNTH is defined; no other dependencies.
`ifndef PER_CPU_PAGE_ALLOCATOR_WITH_STEALING_MACROS_SVH
`define PER_CPU_PAGE_ALLOCATOR_WITH_STEALING_MACROS_SVH
`ifndef SYNTH
// Implication check: whenever ante holds, cons must hold in the same cycle.
`define PCPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle check: whenever ante holds, cons must hold in the next cycle.
`define PCPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
// Plain invariant.
`define PCPA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);
`else
`define PCPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PCPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`define PCPA_ASSERT(lbl, clk, rst_n, prop, msg)
`endif
`endif

>>> src/pcpa_pkg.sv
// Shared types and constants of the per-CPU page allocator.
// Used by the link RAM, datapath, controller and top level.
`default_nettype none

package pcpa_pkg;

	localparam int NUM_CPUS        = 8;
	localparam int CPU_W           = $clog2(NUM_CPUS);
	localparam int PAGE_W          = 10;
	localparam int NUM_PAGES_DEF   = 1024;
	localparam int STEAL_BATCH_DEF = 64;

	// stream payload widths
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 16;

	// request kinds
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	// list link: null flag plus page index
	typedef struct packed {
		logic              is_null;
		logic [PAGE_W-1:0] page;
	} pcpa_link_t;

	localparam pcpa_link_t LINK_NULL = '{is_null: 1'b1, page: '0};

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic exec_free;
		logic exec_pop;
		logic res_empty;
		logic steal_start;
		logic walk_step;
		logic walk_end;
		logic steal_fix;
	} pcpa_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic req_free;
		logic own_empty;
		logic victim_found;
		logic walk_more;
		logic out_busy;
	} pcpa_status_t;

endpackage

`default_nettype wire

>>> src/pcpa_link_ram.sv
// Next-link store: one link per page, one write and one registered read port.
// Depends on pcpa_pkg for the link type.
`default_nettype none

module pcpa_link_ram #(
	parameter int NUM_PAGES = pcpa_pkg::NUM_PAGES_DEF,
	parameter int AW        = $clog2(NUM_PAGES)
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire [AW-1:0]              waddr,
	input  wire pcpa_pkg::pcpa_link_t wdata,
	input  wire [AW-1:0]              raddr,
	output pcpa_pkg::pcpa_link_t      rdata
);
	import pcpa_pkg::*;

	pcpa_link_t mem [NUM_PAGES];
	pcpa_link_t rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> src/pcpa_dp.sv
// Allocator datapath: list heads, link RAM, request and walk registers, result register.
// Depends on pcpa_pkg, pcpa_link_ram and the assertion macro header.
`default_nettype none
`include "per_cpu_page_allocator_with_stealing_macros.svh"

module pcpa_dp #(
	parameter int NUM_PAGES   = pcpa_pkg::NUM_PAGES_DEF,
	parameter int STEAL_BATCH = pcpa_pkg::STEAL_BATCH_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire pcpa_pkg::pcpa_cmd_t      cmd,
	output pcpa_pkg::pcpa_status_t        st,
	input  wire                           cfg_we,
	input  wire [pcpa_pkg::PAGE_W-1:0]    cfg_wdata,
	input  wire                           in_action,
	input  wire [pcpa_pkg::CPU_W-1:0]     in_cpu,
	input  wire [pcpa_pkg::PAGE_W-1:0]    in_page,
	input  wire                           out_ready,
	output logic                          out_valid,
	output logic                          out_granted,
	output logic [pcpa_pkg::PAGE_W-1:0]   out_alloc_page,
	output logic                          out_bad_free
);
	import pcpa_pkg::*;

	localparam int AW    = $clog2(NUM_PAGES);
	localparam int CNT_W = $clog2(STEAL_BATCH + 1);

	// list heads and config
	pcpa_link_t        heads_q [NUM_CPUS];
	logic [PAGE_W-1:0] lowest_q;

	// latched request
	logic              req_action_q;
	logic [CPU_W-1:0]  req_cpu_q;
	logic [PAGE_W-1:0] req_page_q;
	pcpa_link_t        own_head_q;

	// steal walk
	logic [CPU_W-1:0]  victim_q;
	logic [PAGE_W-1:0] steal_head_q;
	logic [PAGE_W-1:0] last_q;
	pcpa_link_t        link_head_q;
	logic [CNT_W-1:0]  cnt_q;

	// result register
	logic              out_valid_q;
	logic              out_granted_q;
	logic [PAGE_W-1:0] out_page_q;
	logic              out_bad_q;

	logic              req_bad;
	logic              victim_found;
	logic [CPU_W-1:0]  victim_sel;
	logic [CPU_W-1:0]  hd_rsel;
	pcpa_link_t        head_rd;
	logic [CPU_W-1:0]  hd_wsel;
	logic              hd_we;
	pcpa_link_t        hd_wdata;
	logic              mem_we;
	logic [PAGE_W-1:0] mem_waddr;
	pcpa_link_t        mem_wdata;
	logic [PAGE_W-1:0] mem_raddr;
	pcpa_link_t        rdata;
	logic              res_load;
	logic [7:0]        cmd_vec;

	// free range check
	assign req_bad = (req_page_q < lowest_q) ||
		({1'b0, req_page_q} >= (PAGE_W + 1)'(NUM_PAGES));

	// first non-empty list of another CPU, ascending
	always_comb begin
		victim_found = 1'b0;
		victim_sel   = '0;
		for (int v = 0; v < NUM_CPUS; v++) begin
			if (!victim_found && (CPU_W'(v) != req_cpu_q) && !heads_q[v].is_null) begin
				victim_found = 1'b1;
				victim_sel   = CPU_W'(v);
			end
		end
	end

	// single head read port
	assign hd_rsel = cmd.steal_start ? victim_sel : in_cpu;
	assign head_rd = heads_q[hd_rsel];

	// single head write port
	assign hd_wsel = cmd.walk_end ? victim_q : req_cpu_q;
	assign hd_we   = (cmd.exec_free && !req_bad) || cmd.exec_pop || cmd.walk_end ||
		cmd.steal_fix;

	always_comb begin
		hd_wdata = rdata;
		if (cmd.exec_free) begin
			hd_wdata = '{is_null: 1'b0, page: req_page_q};
		end else if (cmd.steal_fix) begin
			// a one-page batch leaves the requester empty
			hd_wdata = (last_q == steal_head_q) ? LINK_NULL : link_head_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CPUS; i++) begin
				heads_q[i] <= LINK_NULL;
			end
		end else if (hd_we) begin
			heads_q[hd_wsel] <= hd_wdata;
		end
	end

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lowest_q <= '0;
		end else if (cfg_we) begin
			lowest_q <= cfg_wdata;
		end
	end

	// link RAM addressing
	assign mem_raddr = cmd.walk_step ? rdata.page : head_rd.page;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = req_page_q;
		mem_wdata = own_head_q;
		if (cmd.exec_free && !req_bad) begin
			mem_we = 1'b1;
		end else if (cmd.walk_end) begin
			mem_we    = 1'b1;
			mem_waddr = last_q;
			mem_wdata = LINK_NULL;
		end else if (cmd.steal_fix) begin
			mem_we    = 1'b1;
			mem_waddr = steal_head_q;
			mem_wdata = LINK_NULL;
		end
	end

	pcpa_link_ram #(
		.NUM_PAGES (NUM_PAGES),
		.AW        (AW)
	) u_link_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr[AW-1:0]),
		.wdata (mem_wdata),
		.raddr (mem_raddr[AW-1:0]),
		.rdata (rdata)
	);

	// request and walk registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_action_q <= in_action;
			req_cpu_q    <= in_cpu;
			req_page_q   <= in_page;
			own_head_q   <= head_rd;
		end
		if (cmd.steal_start) begin
			victim_q     <= victim_sel;
			steal_head_q <= head_rd.page;
			last_q       <= head_rd.page;
		end else if (cmd.walk_step) begin
			last_q <= rdata.page;
		end
		// first link read of the walk is the link after the stolen head
		if ((cmd.walk_step || cmd.walk_end) && (cnt_q == CNT_W'(1))) begin
			link_head_q <= rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.steal_start) begin
			cnt_q <= CNT_W'(1);
		end else if (cmd.walk_step) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// result register
	assign res_load = cmd.exec_free || cmd.exec_pop || cmd.res_empty || cmd.steal_fix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_granted_q <= cmd.exec_pop || cmd.steal_fix;
			out_bad_q     <= cmd.exec_free && req_bad;
			if (cmd.exec_pop) begin
				out_page_q <= own_head_q.page;
			end else if (cmd.steal_fix) begin
				out_page_q <= steal_head_q;
			end else begin
				out_page_q <= '0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign out_granted    = out_granted_q;
	assign out_alloc_page = out_page_q;
	assign out_bad_free   = out_bad_q;

	// status to controller
	assign st.req_free     = (req_action_q == ACT_FREE);
	assign st.own_empty    = own_head_q.is_null;
	assign st.victim_found = victim_found;
	assign st.walk_more    = (cnt_q < CNT_W'(STEAL_BATCH)) && !rdata.is_null;
	assign st.out_busy     = out_valid_q && !out_ready;

	assign cmd_vec = cmd;

	// a result must never overwrite one still waiting
	`PCPA_ASSERT_IMP(a_no_result_overrun, clk, arst_n, res_load, !out_valid_q || out_ready, "result register overrun")
	// at most one command per cycle
	`PCPA_ASSERT(a_cmd_onehot, clk, arst_n, $onehot0(cmd_vec), "conflicting datapath commands")
	// walk counter stays within the batch
	`PCPA_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= CNT_W'(STEAL_BATCH), "steal walk ran past batch")

endmodule

`default_nettype wire

>>> src/pcpa_ctrl.sv
// Allocator controller: sequences accept, execute, steal walk and fix-up.
// Depends on pcpa_pkg and the assertion macro header.
`default_nettype none
`include "per_cpu_page_allocator_with_stealing_macros.svh"

module pcpa_ctrl (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire pcpa_pkg::pcpa_status_t st,
	output pcpa_pkg::pcpa_cmd_t         cmd
);
	import pcpa_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_WALK,
		S_FIX
	} state_t;

	state_t state_q;
	state_t state_d;

	// take a request only when idle and the result slot will be free
	assign s_axis_tready = (state_q == S_IDLE) && !st.out_busy;

	// command decode and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid && s_axis_tready) begin
					cmd.accept = 1'b1;
					state_d    = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
				if (st.req_free) begin
					cmd.exec_free = 1'b1;
				end else if (!st.own_empty) begin
					cmd.exec_pop = 1'b1;
				end else if (!st.victim_found) begin
					cmd.res_empty = 1'b1;
				end else begin
					cmd.steal_start = 1'b1;
					state_d         = S_WALK;
				end
			end
			S_WALK: begin
				if (st.walk_more) begin
					cmd.walk_step = 1'b1;
				end else begin
					cmd.walk_end = 1'b1;
					state_d      = S_FIX;
				end
			end
			S_FIX: begin
				cmd.steal_fix = 1'b1;
				state_d       = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// an accepted request is executed in the following cycle
	`PCPA_ASSERT_NXT(a_accept_exec, clk, arst_n, s_axis_tvalid && s_axis_tready, state_q == S_EXEC, "accepted request not executed")
	// fix-up always completes the steal
	`PCPA_ASSERT_NXT(a_fix_done, clk, arst_n, state_q == S_FIX, state_q == S_IDLE, "steal fix-up did not finish")

endmodule

`default_nettype wire

>>> src/per_cpu_page_allocator_with_stealing.sv
// Per-CPU page allocator with batch stealing.
//
// Input stream (s_axis): one request per accepted beat. tuser[0] selects
// allocate (0) or free (1); tdata carries the CPU index and, for a free, the
// page index. Output stream (m_axis): exactly one response per request, in
// order: granted flag, allocated page, bad-free flag.
// cfg_we/cfg_wdata load the lowest freeable page; write it only while idle.
//
// Sequence: a free, a pop from the CPU's own list, or an allocate that finds
// no page anywhere passes through the accept and execute states only. A steal
// goes on to the walk state, which walks 1 to STEAL_BATCH links, and then the
// fix-up state; the walk follows one link per cycle through the single read port
// of the link RAM. The response shows on m_axis in the cycle after the
// request's work ends and is held in an output register.
//
// Reset empties every list and clears lowest page to 0; the link RAM is not
// cleared. While a response waits for m_axis_tready, s_axis_tready is held
// low; the next request can be taken at the edge that hands the response over.
// Depends on pcpa_pkg, pcpa_ctrl and pcpa_dp.
`default_nettype none

module per_cpu_page_allocator_with_stealing #(
	parameter int NUM_PAGES   = pcpa_pkg::NUM_PAGES_DEF,
	parameter int STEAL_BATCH = pcpa_pkg::STEAL_BATCH_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// config
	input  wire                                 cfg_we,
	input  wire [pcpa_pkg::PAGE_W-1:0]          cfg_wdata,   // lowest_page
	// request stream
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire [pcpa_pkg::IN_TDATA_W-1:0]      s_axis_tdata, // cpu[2:0], page[12:3]
	input  wire [0:0]                           s_axis_tuser, // action[0]
	// response stream
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	output logic [pcpa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata  // granted[0], alloc_page[10:1],
	                                                           // bad_free[11]
);
	import pcpa_pkg::*;

	pcpa_cmd_t         cmd;
	pcpa_status_t      st;
	logic              out_granted;
	logic [PAGE_W-1:0] out_alloc_page;
	logic              out_bad_free;

	pcpa_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.st            (st),
		.cmd           (cmd)
	);

	pcpa_dp #(
		.NUM_PAGES   (NUM_PAGES),
		.STEAL_BATCH (STEAL_BATCH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_action      (s_axis_tuser[0]),
		.in_cpu         (s_axis_tdata[CPU_W-1:0]),
		.in_page        (s_axis_tdata[CPU_W+PAGE_W-1:CPU_W]),
		.out_ready      (m_axis_tready),
		.out_valid      (m_axis_tvalid),
		.out_granted    (out_granted),
		.out_alloc_page (out_alloc_page),
		.out_bad_free   (out_bad_free)
	);

	// response packing, zero fill to byte boundary
	assign m_axis_tdata = {(OUT_TDATA_W - PAGE_W - 2)'(0), out_bad_free, out_alloc_page,
		out_granted};

endmodule

`default_nettype wire

>>> tb/sv/pcpa_tb_pkg.sv
// Scoreboard for the per-CPU page allocator testbench: a free-list tracker
// that works out each response and checks the responses as they arrive.
// Depends on pcpa_pkg for the link type, request kinds and sizes.
package pcpa_tb_pkg;

	import pcpa_pkg::*;

	// one response, fields as they travel on m_axis_tdata
	typedef struct packed {
		logic              bad_free;
		logic [PAGE_W-1:0] alloc_page;
		logic              granted;
	} alloc_resp_t;

	class alloc_checker;
		pcpa_link_t        heads [NUM_CPUS];
		pcpa_link_t        links [NUM_PAGES_DEF];
		logic [PAGE_W-1:0] lowest;
		alloc_resp_t       expected_resps [$];
		int                errors;

		function new();
			for (int i = 0; i < NUM_CPUS; i++) begin
				heads[i] = LINK_NULL;
			end
			lowest = '0;
			errors = 0;
		endfunction

		function void set_lowest(logic [PAGE_W-1:0] value);
			lowest = value;
		endfunction

		function int pending();
			return expected_resps.size();
		endfunction

		// Apply one request to the tracked lists and return its response.
		function alloc_resp_t apply_request(logic act, logic [CPU_W-1:0] cpu,
				logic [PAGE_W-1:0] page);
			alloc_resp_t resp;
			pcpa_link_t  head;
			pcpa_link_t  tail;
			bit          taken;
			resp = '0;
			taken = 0;
			if (act == ACT_FREE) begin
				if (page < lowest) begin
					resp.bad_free = 1'b1;
				end else begin
					links[page] = heads[cpu];
					heads[cpu] = '{is_null: 1'b0, page: page};
				end
			end else if (!heads[cpu].is_null) begin
				// pop from the CPU's own list
				resp.granted = 1'b1;
				resp.alloc_page = heads[cpu].page;
				heads[cpu] = links[heads[cpu].page];
			end else begin
				// own list empty: steal a batch from the first non-empty victim
				for (int v = 0; v < NUM_CPUS; v++) begin
					if (!taken && v != int'(cpu) && !heads[v].is_null) begin
						head = heads[v];
						tail = head;
						for (int n = 1; n < STEAL_BATCH_DEF && !links[tail.page].is_null; n++) begin
							tail = links[tail.page];
						end
						heads[v] = links[tail.page];
						links[tail.page] = LINK_NULL;
						heads[cpu] = links[head.page];
						links[head.page] = LINK_NULL;
						resp.granted = 1'b1;
						resp.alloc_page = head.page;
						taken = 1;
					end
				end
			end
			return resp;
		endfunction

		function void note_request(logic act, logic [CPU_W-1:0] cpu,
				logic [PAGE_W-1:0] page);
			expected_resps.push_back(apply_request(act, cpu, page));
		endfunction

		function void check_response(logic [OUT_TDATA_W-1:0] tdata);
			alloc_resp_t want;
			alloc_resp_t got;
			got = tdata[$bits(alloc_resp_t)-1:0];
			if (expected_resps.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected response: granted=%0d page=%0d bad_free=%0d",
						got.granted, got.alloc_page, got.bad_free);
				return;
			end
			want = expected_resps.pop_front();
			if (got.granted !== want.granted || got.alloc_page !== want.alloc_page ||
					got.bad_free !== want.bad_free || tdata[OUT_TDATA_W-1:$bits(alloc_resp_t)] !== '0) begin
				errors++;
				if (errors <= 10)
					$display("response mismatch: expected granted=%0d page=%0d bad_free=%0d, got granted=%0d page=%0d bad_free=%0d (tdata=%h)",
						want.granted, want.alloc_page, want.bad_free,
						got.granted, got.alloc_page, got.bad_free, tdata);
			end
		endfunction
	endclass

endpackage

>>> tb/sv/tb_top.sv
// Top of the page allocator testbench: clock, reset, request and response
// stream drivers, lowest-page writes, directed and random request phases.
// Depends on pcpa_pkg, pcpa_tb_pkg and per_cpu_page_allocator_with_stealing.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pcpa_pkg::*;
	import pcpa_tb_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 80;
	localparam int RAND_PHASES = 6;
	localparam int RAND_ITEMS = 225;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [PAGE_W-1:0]      cfg_wdata;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic [0:0]             s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	int src_idle_pct;
	int sink_idle_pct;
	alloc_checker tracker;

	per_cpu_page_allocator_with_stealing dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	// response side: random back-pressure, changed on the falling edge
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			m_axis_tready = ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// response monitor
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tracker.check_response(m_axis_tdata);
	end

	// Send one request; returns right after the edge that accepted it.
	task automatic send_req(input logic act, input logic [CPU_W-1:0] cpu,
			input logic [PAGE_W-1:0] page);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser = act;
		s_axis_tdata = {{(IN_TDATA_W-PAGE_W-CPU_W){1'b0}}, page, cpu};
		do @(posedge clk); while (!s_axis_tready);
		tracker.note_request(act, cpu, page);
	endtask

	task automatic alloc_req(input logic [CPU_W-1:0] cpu);
		send_req(ACT_ALLOC, cpu, PAGE_W'($urandom_range(NUM_PAGES_DEF-1)));
	endtask

	// Stop sending and wait until every response is back.
	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (tracker.pending() > 0) @(posedge clk);
	endtask

	task automatic write_lowest(input logic [PAGE_W-1:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		tracker.set_lowest(value);
	endtask

	// Page in the freeable range most of the time, anything otherwise.
	function automatic logic [PAGE_W-1:0] pick_page(int valid_pct);
		if ($urandom_range(99) < valid_pct)
			return PAGE_W'($urandom_range(NUM_PAGES_DEF-1, int'(tracker.lowest)));
		return PAGE_W'($urandom);
	endfunction

	// Random requests in runs: bulk frees, drains that force steals, mixes, noise.
	task automatic random_requests(input int count);
		int sent;
		int kind;
		int run_len;
		bit paused;
		logic [CPU_W-1:0] cpu_a;
		logic [CPU_W-1:0] cpu_b;
		sent = 0;
		paused = 0;
		while (sent < count) begin
			kind = $urandom_range(9);
			cpu_a = CPU_W'($urandom);
			cpu_b = CPU_W'($urandom);
			run_len = (kind <= 2) ? $urandom_range(80, 8) : $urandom_range(50, 10);
			for (int i = 0; i < run_len && sent < count; i++) begin
				if (kind <= 2) begin
					send_req(ACT_FREE, cpu_a, pick_page(95));
				end else if (kind <= 5) begin
					alloc_req(($urandom_range(3) == 0) ? CPU_W'($urandom) :
						($urandom_range(1) ? cpu_a : cpu_b));
				end else if (kind <= 8) begin
					if ($urandom_range(1))
						send_req(ACT_FREE, CPU_W'($urandom), pick_page(90));
					else
						alloc_req(CPU_W'($urandom));
				end else begin
					send_req(logic'($urandom_range(1)), CPU_W'($urandom), PAGE_W'($urandom));
				end
				sent++;
			end
			// hold the sender once per phase until the block has answered everything
			if (!paused && sent >= count / 2) begin
				wait_drained();
				paused = 1;
			end
		end
	endtask

	initial begin
		logic [PAGE_W-1:0] lowest_set [RAND_PHASES];
		tracker = new();
		lowest_set = '{10'd5, 10'd512, 10'd0, 10'd1023, 10'd200, 10'd64};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		src_idle_pct = 37;
		sink_idle_pct = 60;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty allocs, edge pages, own pop, steals, double free
		write_lowest(10'd0);
		alloc_req(3'd0);
		alloc_req(3'd7);
		send_req(ACT_FREE, 3'd0, 10'd0);
		send_req(ACT_FREE, 3'd7, 10'd1023);
		send_req(ACT_FREE, 3'd7, 10'd512);
		alloc_req(3'd0);
		alloc_req(3'd0);
		alloc_req(3'd7);
		alloc_req(3'd3);
		send_req(ACT_FREE, 3'd2, 10'd5);
		send_req(ACT_FREE, 3'd2, 10'd5);
		alloc_req(3'd2);
		alloc_req(3'd4);
		alloc_req(3'd4);
		alloc_req(3'd2);
		wait_drained();

		// directed: out-of-range frees at the highest lowest page
		write_lowest(10'd1023);
		send_req(ACT_FREE, 3'd1, 10'd1022);
		send_req(ACT_FREE, 3'd6, 10'd0);
		send_req(ACT_FREE, 3'd1, 10'd1023);
		alloc_req(3'd6);
		alloc_req(3'd6);
		wait_drained();

		// random phases; idle mix changes every two phases
		for (int p = 0; p < RAND_PHASES; p++) begin
			if (p < 2) begin
				src_idle_pct = 37;
				sink_idle_pct = 60;
			end else if (p < 4) begin
				src_idle_pct = 60;
				sink_idle_pct = 37;
			end else begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end
			write_lowest(lowest_set[p]);
			random_requests(RAND_ITEMS);
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
